>>> rtl/pcac_pkg.sv
// shared types and constants for the alpha / chroma key pixel compositor
package pcac_pkg;

   // field widths
   localparam int PIXEL_W   = 32;
   localparam int CH_W      = 8;
   localparam int PROD_W    = 16;
   localparam int SUM_W     = 17;
   localparam int DIST_W    = 18;
   localparam int MODE_W    = 2;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 18;
   localparam int NUM_CH    = 3;

   // constants of the arithmetic
   localparam logic [CH_W-1:0]   CH_MAX    = 8'hff;
   localparam logic [CH_W-1:0]   CH_ZERO   = 8'h00;
   localparam logic [DIST_W-1:0] SKIP_DIST = 18'd32;
   localparam logic [SUM_W-1:0]  ROUND     = 17'd256;

   // blend mode codes
   localparam logic [MODE_W-1:0] MODE_COPY   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ALPHA  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CHROMA = 2'd2;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_MODE   = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] REG_THRESH = 1'b1;

   // what the output stage does with a word
   typedef enum logic [1:0] {
      ACT_SKIP  = 2'd0,
      ACT_COPY  = 2'd1,
      ACT_BLEND = 2'd2
   } action_type;

   // configuration as seen by the datapath
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [DIST_W-1:0] threshold;
   } csr_type;

   // stage 1: squares and spill product
   typedef struct packed {
      logic [PIXEL_W-1:0] top;
      logic [PIXEL_W-1:0] bot;
      logic [PROD_W-1:0]  r_sq;
      logic [PROD_W-1:0]  g_sq;
      logic [PROD_W-1:0]  b_sq;
      logic [PROD_W-1:0]  spill;
   } dist_type;

   // stage 2: decision and blend source
   typedef struct packed {
      action_type         act;
      logic [PIXEL_W-1:0] src;
      logic [PIXEL_W-1:0] bot;
   } sel_type;

   // stage 3: blend products per channel
   typedef struct packed {
      action_type                     act;
      logic [PIXEL_W-1:0]             src;
      logic [PIXEL_W-1:0]             bot;
      logic [NUM_CH-1:0][PROD_W-1:0]  top_prod;
      logic [NUM_CH-1:0][PROD_W-1:0]  bot_prod;
   } prod_type;

endpackage

>>> rtl/pcac_dist.sv
// stage 1: squared distance terms to pure green and the green spill product
module pcac_dist (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [pcac_pkg::PIXEL_W-1:0] top,
   input  logic [pcac_pkg::PIXEL_W-1:0] bot,
   output logic                      out_valid,
   input  logic                      out_ready,
   output pcac_pkg::dist_type        out_data
);

   logic               valid_ff;
   pcac_pkg::dist_type data_ff;
   pcac_pkg::dist_type data_in;
   logic [pcac_pkg::CH_W-1:0] red;
   logic [pcac_pkg::CH_W-1:0] green;
   logic [pcac_pkg::CH_W-1:0] blue;
   logic [pcac_pkg::CH_W-1:0] green_inv;

   // stage takes a word when empty or when its word moves on
   assign in_ready = !valid_ff || out_ready;

   // channel squares and spill product
   always_comb begin
      red       = top[23:16];
      green     = top[15:8];
      blue      = top[7:0];
      green_inv = pcac_pkg::CH_MAX - green;
      data_in.top   = top;
      data_in.bot   = bot;
      data_in.r_sq  = 16'(red) * 16'(red);
      data_in.g_sq  = 16'(green_inv) * 16'(green_inv);
      data_in.b_sq  = 16'(blue) * 16'(blue);
      data_in.spill = 16'(green_inv) * 16'(green);
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> rtl/pcac_select.sv
// stage 2: distance sum, mode decision and blend source pixel
module pcac_select (
   input  logic                clock,
   input  logic                reset,
   input  pcac_pkg::csr_type   csr,
   input  logic                in_valid,
   output logic                in_ready,
   input  pcac_pkg::dist_type  in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output pcac_pkg::sel_type   out_data
);

   logic              valid_ff;
   pcac_pkg::sel_type data_ff;
   pcac_pkg::sel_type data_in;
   logic [pcac_pkg::DIST_W-1:0] key_dist;
   logic [pcac_pkg::SUM_W-1:0]  spill_sum;
   logic [pcac_pkg::CH_W-1:0]   new_green;
   logic [pcac_pkg::CH_W-1:0]   key_alpha;
   logic [pcac_pkg::CH_W-1:0]   top_alpha;

   assign in_ready = !valid_ff || out_ready;

   // decide skip, copy or blend
   always_comb begin
      key_dist  = 18'(in_data.r_sq) + 18'(in_data.g_sq) + 18'(in_data.b_sq);
      spill_sum = 17'(in_data.spill) + pcac_pkg::ROUND;
      new_green = spill_sum[15:8];
      key_alpha = pcac_pkg::CH_MAX - in_data.top[15:8];
      top_alpha = in_data.top[31:24];
      data_in.bot = in_data.bot;
      data_in.src = in_data.top;
      data_in.act = pcac_pkg::ACT_COPY;
      case (csr.mode)
         pcac_pkg::MODE_ALPHA: begin
            if (top_alpha == pcac_pkg::CH_MAX) begin
               data_in.act = pcac_pkg::ACT_COPY;
            end else if (top_alpha != pcac_pkg::CH_ZERO) begin
               data_in.act = pcac_pkg::ACT_BLEND;
            end else begin
               data_in.act = pcac_pkg::ACT_SKIP;
            end
         end
         pcac_pkg::MODE_CHROMA: begin
            if (key_dist < pcac_pkg::SKIP_DIST) begin
               data_in.act = pcac_pkg::ACT_SKIP;
            end else if (key_dist > csr.threshold) begin
               data_in.act = pcac_pkg::ACT_COPY;
            end else begin
               // translucent key pixel with green spill pulled down
               data_in.act = pcac_pkg::ACT_BLEND;
               data_in.src = {key_alpha, in_data.top[23:16], new_green, in_data.top[7:0]};
            end
         end
         default: begin
            data_in.act = pcac_pkg::ACT_COPY;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> rtl/pcac_mult.sv
// stage 3: per-channel blend products of source and destination
module pcac_mult (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  pcac_pkg::sel_type  in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output pcac_pkg::prod_type out_data
);

   logic               valid_ff;
   pcac_pkg::prod_type data_ff;
   pcac_pkg::prod_type data_in;
   logic [pcac_pkg::CH_W-1:0] alpha;
   logic [pcac_pkg::CH_W-1:0] alpha_inv;

   assign in_ready = !valid_ff || out_ready;

   // a*t and (255-a)*b for each color lane
   always_comb begin
      alpha     = in_data.src[31:24];
      alpha_inv = pcac_pkg::CH_MAX - alpha;
      data_in.act = in_data.act;
      data_in.src = in_data.src;
      data_in.bot = in_data.bot;
      for (int i = 0; i < pcac_pkg::NUM_CH; i++) begin
         data_in.top_prod[i] = 16'(alpha) * 16'(in_data.src[i*pcac_pkg::CH_W +: pcac_pkg::CH_W]);
         data_in.bot_prod[i] = 16'(alpha_inv) *
                               16'(in_data.bot[i*pcac_pkg::CH_W +: pcac_pkg::CH_W]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> rtl/pcac_out.sv
// stage 4: rounded channel sums, result selection and output register
module pcac_out (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  pcac_pkg::prod_type           in_data,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [pcac_pkg::PIXEL_W-1:0] out_pixel,
   output logic                         out_write
);

   logic                         valid_ff;
   logic [pcac_pkg::PIXEL_W-1:0] pixel_ff;
   logic [pcac_pkg::PIXEL_W-1:0] pixel_in;
   logic                         write_ff;
   logic                         write_in;
   logic [pcac_pkg::NUM_CH-1:0][pcac_pkg::SUM_W-1:0] sum;
   logic [pcac_pkg::PIXEL_W-1:0] blended;

   assign in_ready = !valid_ff || out_ready;

   // round, drop the low byte and pick the result
   always_comb begin
      blended = {pcac_pkg::CH_MAX, 24'h000000};
      for (int i = 0; i < pcac_pkg::NUM_CH; i++) begin
         sum[i] = 17'(in_data.top_prod[i]) + 17'(in_data.bot_prod[i]) + pcac_pkg::ROUND;
         blended[i*pcac_pkg::CH_W +: pcac_pkg::CH_W] = sum[i][15:8];
      end
      case (in_data.act)
         pcac_pkg::ACT_BLEND: begin
            pixel_in = blended;
            write_in = 1'b1;
         end
         pcac_pkg::ACT_COPY: begin
            pixel_in = in_data.src;
            write_in = 1'b1;
         end
         default: begin
            pixel_in = in_data.bot;
            write_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         pixel_ff <= pixel_in;
         write_ff <= write_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_pixel = pixel_ff;
   assign out_write = write_ff;

endmodule

>>> rtl/pixel_compositor_alpha_chroma_top.sv
// top level of the alpha blend and green chroma key pixel compositor
// Takes one top/bottom ARGB pixel pair per clock while req_tready is high and
// returns one result word per pair. The work runs through four register stages
// (distance squares, mode decision, blend multiplies, rounded sums into the output
// register), each with its own valid bit, so a pair can enter every cycle and a
// stalled result side only holds the stages that are full; empty stages behind it
// keep taking words. Mode and threshold are read straight from the registers, so
// write them only while no word is in flight.
module pixel_compositor_alpha_chroma_top (
   input  logic                            clock,
   input  logic                            reset,
   // input words
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [2*pcac_pkg::PIXEL_W-1:0]  req_tdata,   // bottom_pixel, top_pixel
   // result words
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [pcac_pkg::PIXEL_W-1:0]    rsp_tdata,   // result_pixel
   output logic                            rsp_tuser,   // write_enable
   // register writes
   input  logic                            csr_we,
   input  logic [pcac_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [pcac_pkg::CSR_DATA_W-1:0] csr_wdata
);

   logic [pcac_pkg::MODE_W-1:0] mode_ff;
   logic [pcac_pkg::DIST_W-1:0] thresh_ff;
   pcac_pkg::csr_type           csr;

   logic               s1_valid, s1_ready;
   pcac_pkg::dist_type s1_data;
   logic               s2_valid, s2_ready;
   pcac_pkg::sel_type  s2_data;
   logic               s3_valid, s3_ready;
   pcac_pkg::prod_type s3_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= pcac_pkg::MODE_COPY;
         thresh_ff <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            pcac_pkg::REG_MODE:   mode_ff   <= csr_wdata[pcac_pkg::MODE_W-1:0];
            pcac_pkg::REG_THRESH: thresh_ff <= csr_wdata[pcac_pkg::DIST_W-1:0];
            default: ;
         endcase
      end
   end

   assign csr.mode      = mode_ff;
   assign csr.threshold = thresh_ff;

   // pipeline stages
   pcac_dist u_dist (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .top       (req_tdata[pcac_pkg::PIXEL_W-1:0]),
      .bot       (req_tdata[2*pcac_pkg::PIXEL_W-1:pcac_pkg::PIXEL_W]),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_data  (s1_data)
   );

   pcac_select u_select (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_data  (s2_data)
   );

   pcac_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_data   (s2_data),
      .out_valid (s3_valid),
      .out_ready (s3_ready),
      .out_data  (s3_data)
   );

   pcac_out u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid),
      .in_ready  (s3_ready),
      .in_data   (s3_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_pixel (rsp_tdata),
      .out_write (rsp_tuser)
   );

   // an empty first stage always takes a word
   a_empty_takes: assert property (@(posedge clock) disable iff (reset)
      !s1_valid |-> req_tready)
      else $error("input stalled with empty first stage");

   // input stalls only when every stage holds a word
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_valid && s2_valid && s3_valid && rsp_tvalid && !rsp_tready))
      else $error("input stalled with a bubble in the pipeline");

   // a skipped word never carries a blended or copied action into the output
   a_skip_flag: assert property (@(posedge clock) disable iff (reset)
      (s3_valid && s3_ready && s3_data.act == pcac_pkg::ACT_SKIP) |=> !rsp_tuser)
      else $error("skipped word flagged as written");

endmodule
